>>> rtl/glob_wildcard_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// Glob wildcard matcher assertion macros
// Shared assertion helpers for the matcher; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_TOP_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define GWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gwm assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gwm assertion failed");
`else
`define GWM_ASSERT_NOW(lbl, ante, cons)
`define GWM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Request and result types, operation codes, wildcard bytes, case fold.
// ----------------------------------------------------------------------------
package gwm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } gwm_op_e;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
  } gwm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } gwm_out_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic       text_step;
    logic       restart;
    logic       case_fold;
    logic [7:0] char_val;
  } gwm_ctrl_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold);
    logic [7:0] r;
    r = c;
    if (fold && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> rtl/gwm_cell.sv
// ----------------------------------------------------------------------------
// Glob wildcard matcher cell
// One pattern position: stored byte, active bit, token and star hand-off.
// ----------------------------------------------------------------------------
module gwm_cell #(
  parameter bit ACT_RESET = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gwm_pkg::gwm_ctrl_t ctrl_i,
  input  logic              wr_i,
  input  logic              en_i,
  input  logic              shift_i,
  input  logic              close_i,
  output logic              tok_o,
  output logic              close_o,
  output logic              act_o
);
  import gwm_pkg::*;

  logic [7:0] pat_q;
  logic [7:0] pat_eff;
  logic       act_q;
  logic       act_d;
  logic       is_star;
  logic       is_hit;
  logic       upd;

  // The byte being appended already counts for the star ripple.
  assign pat_eff = wr_i ? ctrl_i.char_val : pat_q;
  assign is_star = en_i && (pat_eff == STAR_CHAR);
  assign is_hit  = (pat_q == ANY_CHAR) ||
                   (fold_char(pat_q, ctrl_i.case_fold) ==
                    fold_char(ctrl_i.char_val, ctrl_i.case_fold));
  assign upd     = ctrl_i.text_step || ctrl_i.restart;

  always_comb begin
    act_d = act_q;
    if (upd) begin
      act_d = shift_i || close_i || (ctrl_i.text_step && act_q && is_star);
    end
  end

  assign tok_o   = ctrl_i.text_step && act_q && en_i && !is_star && is_hit;
  assign close_o = upd && act_d && is_star;
  assign act_o   = act_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      pat_q <= ctrl_i.char_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_RESET;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

>>> rtl/glob_wildcard_matcher_top.sv
// ----------------------------------------------------------------------------
// Glob wildcard matcher top level
// Row of pattern cells matching streamed text against a glob pattern.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle for every operation; an end-of-text
//   request waits only while the previous result is held by a low out_ready_i.
// Result: an end-of-text request shows its result on out_valid_o in the cycle
//   after it is accepted; other requests produce no result.
// Reset: pattern empty, overflow clear, case fold off, position zero active,
//   no result pending; the pattern bytes hold no value until appended.
`include "glob_wildcard_matcher_top_defines.svh"

module glob_wildcard_matcher_top #(
  parameter int MAX_PATTERN = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gwm_pkg::gwm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gwm_pkg::gwm_out_t out_data_o
);
  import gwm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  // Configuration and pattern bookkeeping.
  logic          case_fold_q;
  logic [LW-1:0] len_q;
  logic [LW-1:0] len_d;
  logic          ovf_q;
  logic          ovf_d;
  logic          full;

  // Request decode.
  logic      in_acc;
  logic      acc_clear;
  logic      acc_append;
  logic      acc_text;
  logic      acc_end;
  gwm_ctrl_t ctrl;

  // Cell row signals; position MAX_PATTERN lives here, past the last cell.
  logic [MAX_PATTERN-1:0] wr;
  logic [MAX_PATTERN-1:0] en;
  logic [MAX_PATTERN-1:0] tok;
  logic [MAX_PATTERN-1:0] close;
  logic [MAX_PATTERN:0]   act_all;
  logic                   act_last_q;
  logic                   act_last_d;

  // Result register.
  logic     out_valid_q;
  gwm_out_t out_data_q;

  // Hold only an end-of-text request while an earlier result is not taken.
  assign in_ready_o = !out_valid_q || out_ready_i || (in_data_i.operation != OP_END);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    acc_clear  = 1'b0;
    acc_append = 1'b0;
    acc_text   = 1'b0;
    acc_end    = 1'b0;
    case (in_data_i.operation)
      OP_CLEAR:  acc_clear  = in_acc;
      OP_APPEND: acc_append = in_acc;
      OP_TEXT:   acc_text   = in_acc;
      OP_END:    acc_end    = in_acc;
      default:   acc_text   = 1'b0;
    endcase
  end

  assign full = (len_q == LW'(MAX_PATTERN));

  // Advance the length on append; drop the byte and flag it once full.
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (acc_clear) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else if (acc_append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + LW'(1);
      end
    end
  end

  // Clear, append and end of text all restart the current string.
  assign ctrl.text_step = acc_text;
  assign ctrl.restart   = acc_clear || acc_append || acc_end;
  assign ctrl.case_fold = case_fold_q;
  assign ctrl.char_val  = in_data_i.character;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    // Write the appended byte into the first free position.
    assign wr[i] = acc_append && !full && (len_q == LW'(i));
    // A position takes part only below the updated pattern length.
    assign en[i] = (LW'(i) < len_d);

    if (i == 0) begin : g_head
      gwm_cell #(
        .ACT_RESET(1'b1)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .wr_i    (wr[i]),
        .en_i    (en[i]),
        .shift_i (ctrl.restart),
        .close_i (1'b0),
        .tok_o   (tok[i]),
        .close_o (close[i]),
        .act_o   (act_all[i])
      );
    end else begin : g_body
      gwm_cell #(
        .ACT_RESET(1'b0)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .wr_i    (wr[i]),
        .en_i    (en[i]),
        .shift_i (tok[i-1]),
        .close_i (close[i-1]),
        .tok_o   (tok[i]),
        .close_o (close[i]),
        .act_o   (act_all[i])
      );
    end
  end

  // Final position: reached by a match or a star in the last cell.
  always_comb begin
    act_last_d = act_last_q;
    if (ctrl.text_step || ctrl.restart) begin
      act_last_d = tok[MAX_PATTERN-1] || close[MAX_PATTERN-1];
    end
  end

  assign act_all[MAX_PATTERN] = act_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_fold_q <= 1'b0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      act_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case_fold_q <= cfg_wdata_i;
      end
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      act_last_q <= act_last_d;
      // Load a result on end of text; drop it once taken.
      if (acc_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_end) begin
      out_data_q.matched          <= act_all[len_q];
      out_data_q.pattern_overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `GWM_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LW'(MAX_PATTERN))
  `GWM_ASSERT_NOW(a_act_below_len, 1'b1, ((act_all >> len_q) >> 1) == '0)
  `GWM_ASSERT_NEXT(a_end_gives_result, acc_end, out_valid_q)
  `GWM_ASSERT_NEXT(a_clear_drops_ovf, acc_clear, !ovf_q && (len_q == '0))

endmodule
